// ===== hdl/gsqm_pkg.sv =====
`default_nettype none

package gsqm_pkg;

    // Grid and id sizing
    localparam int MAX_ROWS  = 1024;
    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int CFG_BITS  = 11;
    localparam int ID_BITS   = 22;
    localparam int PID_BITS  = ID_BITS + 1;

    localparam logic [ID_BITS-1:0]  ID_MAX     = {ID_BITS{1'b1}};
    localparam logic [PID_BITS-1:0] PID_NONE   = {PID_BITS{1'b1}};
    localparam logic [CFG_BITS-1:0] ROWS_RESET = CFG_BITS'(MAX_ROWS);

    // One word of the column line store
    typedef struct packed {
        logic               valid;
        logic [ID_BITS-1:0] id;
    } ram_word_t;

    // What the front stage hands to the result stage for one sample
    typedef struct packed {
        logic               sample_valid;
        logic [ID_BITS-1:0] id;
        logic [ID_BITS-1:0] below_id;
        logic               anchor_ok;
        logic               prior_ok;
        logic               overflow;
    } gsqm_item_t;

endpackage

`default_nettype wire

// ===== hdl/grid_scan_quad_mesher.sv =====
// Channel   Handshake          Beat contents
// s_        s_valid/s_ready    s_sample_valid, s_scan_start
// m_        m_valid/m_ready    m_point_id, m_quad_emit, four quad ids, m_id_overflow
// cfg       cfg_we             cfg_wdata = rows_per_column
//
// One sample per cycle sustained while m_ channel is not stalled; an input beat reaches
// the result beat through the front register plus line store read, then the result register.
// The column line store takes one read-before-write per beat at the row address.
// Synchronous active-low reset; no clearing pass: a fill mark tracks written rows.
// A stalled m_ channel holds its beat while one more input beat is taken.
`default_nettype none

module grid_scan_quad_mesher (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [gsqm_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_sample_valid,
    input  logic                           s_scan_start,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [gsqm_pkg::PID_BITS-1:0] m_point_id,
    output logic                           m_quad_emit,
    output logic [gsqm_pkg::ID_BITS-1:0]   m_quad_id_anchor,
    output logic [gsqm_pkg::ID_BITS-1:0]   m_quad_id_up,
    output logic [gsqm_pkg::ID_BITS-1:0]   m_quad_id_left_up,
    output logic [gsqm_pkg::ID_BITS-1:0]   m_quad_id_left,
    output logic                           m_id_overflow
);
    import gsqm_pkg::*;

    logic                st_valid;
    logic                st_take;
    gsqm_item_t          st_item;
    logic                ram_en;
    logic [ROW_BITS-1:0] ram_addr;
    ram_word_t           ram_wdata;
    ram_word_t           ram_rdata;
    logic [PID_BITS-1:0] point_id;

    gsqm_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_valid (s_sample_valid),
        .s_scan_start   (s_scan_start),
        .st_take        (st_take),
        .st_valid       (st_valid),
        .st_item        (st_item),
        .ram_en         (ram_en),
        .ram_addr       (ram_addr),
        .ram_wdata      (ram_wdata)
    );

    gsqm_line_ram u_line_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    gsqm_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .st_valid          (st_valid),
        .st_item           (st_item),
        .ram_rdata         (ram_rdata),
        .st_take           (st_take),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_point_id        (point_id),
        .m_quad_emit       (m_quad_emit),
        .m_quad_id_anchor  (m_quad_id_anchor),
        .m_quad_id_up      (m_quad_id_up),
        .m_quad_id_left_up (m_quad_id_left_up),
        .m_quad_id_left    (m_quad_id_left),
        .m_id_overflow     (m_id_overflow)
    );

    assign m_point_id = $signed(point_id);

endmodule

`default_nettype wire

// ===== hdl/gsqm_line_ram.sv =====
`default_nettype none

module gsqm_line_ram (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [gsqm_pkg::ROW_BITS-1:0]  addr,
    input  gsqm_pkg::ram_word_t            wdata,
    output gsqm_pkg::ram_word_t            rdata
);
    import gsqm_pkg::*;

    ram_word_t mem [MAX_ROWS];
    ram_word_t rdata_reg;

    // Read the old word, then overwrite it with the new column's word
    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/gsqm_front.sv =====
`default_nettype none

module gsqm_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [gsqm_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_sample_valid,
    input  logic                           s_scan_start,
    input  logic                           st_take,
    output logic                           st_valid,
    output gsqm_pkg::gsqm_item_t           st_item,
    output logic                           ram_en,
    output logic [gsqm_pkg::ROW_BITS-1:0]  ram_addr,
    output gsqm_pkg::ram_word_t            ram_wdata
);
    import gsqm_pkg::*;

    logic [CFG_BITS-1:0] rows_cfg_reg;
    logic [ROW_BITS-1:0] row_pos_reg, row_pos_next;
    logic                past_first_reg, past_first_next;
    logic [ID_BITS-1:0]  cnt_reg, cnt_next;
    logic                below_valid_reg;
    logic [ID_BITS-1:0]  below_id_reg;
    logic [CFG_BITS-1:0] fill_reg, fill_next;
    logic                st_valid_reg, st_valid_next;
    gsqm_item_t          st_item_reg, st_item_next;

    logic                accept;
    logic [CFG_BITS-1:0] rows_eff;
    logic [ROW_BITS-1:0] pos_base, p;
    logic [CFG_BITS-1:0] p_wide, p_inc;
    logic                past_base;
    logic [ID_BITS-1:0]  cnt_base, id;
    logic                below_valid;

    assign s_ready = !st_valid_reg || st_take;
    assign accept  = s_valid && s_ready;

    // Clamp the row count into 1..MAX_ROWS
    always_comb begin
        if (rows_cfg_reg == '0) begin
            rows_eff = CFG_BITS'(1);
        end else if (rows_cfg_reg > ROWS_RESET) begin
            rows_eff = ROWS_RESET;
        end else begin
            rows_eff = rows_cfg_reg;
        end
    end

    // Position, numbering and neighbor bookkeeping for the incoming beat
    always_comb begin
        pos_base  = s_scan_start ? '0 : row_pos_reg;
        past_base = s_scan_start ? 1'b0 : past_first_reg;
        cnt_base  = s_scan_start ? '0 : cnt_reg;

        p      = (CFG_BITS'(pos_base) >= rows_eff) ? '0 : pos_base;
        p_wide = CFG_BITS'(p);
        p_inc  = p_wide + CFG_BITS'(1);

        id       = s_sample_valid ? cnt_base : '0;
        cnt_next = (s_sample_valid && cnt_base != ID_MAX) ? cnt_base + ID_BITS'(1) : cnt_base;

        below_valid = (p != '0) && below_valid_reg;

        if (p_inc >= rows_eff) begin
            row_pos_next    = '0;
            past_first_next = 1'b1;
        end else begin
            row_pos_next    = p_inc[ROW_BITS-1:0];
            past_first_next = past_base;
        end

        // Written rows always form a prefix starting at row zero
        fill_next = (p_inc > fill_reg) ? p_inc : fill_reg;

        st_item_next.sample_valid = s_sample_valid;
        st_item_next.id           = id;
        st_item_next.below_id     = below_id_reg;
        st_item_next.anchor_ok    = (p != '0) && past_base && below_valid;
        st_item_next.prior_ok     = p_wide < fill_reg;
        st_item_next.overflow     = (cnt_next == ID_MAX);

        if (accept) begin
            st_valid_next = 1'b1;
        end else if (st_take) begin
            st_valid_next = 1'b0;
        end else begin
            st_valid_next = st_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg    <= ROWS_RESET;
            row_pos_reg     <= '0;
            past_first_reg  <= 1'b0;
            cnt_reg         <= '0;
            below_valid_reg <= 1'b0;
            below_id_reg    <= '0;
            fill_reg        <= '0;
            st_valid_reg    <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
            if (cfg_we) begin
                rows_cfg_reg <= cfg_wdata;
            end
            if (accept) begin
                row_pos_reg     <= row_pos_next;
                past_first_reg  <= past_first_next;
                cnt_reg         <= cnt_next;
                below_valid_reg <= s_sample_valid;
                below_id_reg    <= id;
                fill_reg        <= fill_next;
            end
        end
    end

    // Hold the beat for the result stage
    always_ff @(posedge aclk) begin
        if (accept) begin
            st_item_reg <= st_item_next;
        end
    end

    assign st_valid        = st_valid_reg;
    assign st_item         = st_item_reg;
    assign ram_en          = accept;
    assign ram_addr        = p;
    assign ram_wdata.valid = s_sample_valid;
    assign ram_wdata.id    = id;

endmodule

`default_nettype wire

// ===== hdl/gsqm_back.sv =====
`default_nettype none

module gsqm_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           st_valid,
    input  gsqm_pkg::gsqm_item_t           st_item,
    input  gsqm_pkg::ram_word_t            ram_rdata,
    output logic                           st_take,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [gsqm_pkg::PID_BITS-1:0]  m_point_id,
    output logic                           m_quad_emit,
    output logic [gsqm_pkg::ID_BITS-1:0]   m_quad_id_anchor,
    output logic [gsqm_pkg::ID_BITS-1:0]   m_quad_id_up,
    output logic [gsqm_pkg::ID_BITS-1:0]   m_quad_id_left_up,
    output logic [gsqm_pkg::ID_BITS-1:0]   m_quad_id_left,
    output logic                           m_id_overflow
);
    import gsqm_pkg::*;

    logic                bl_valid_reg;
    logic [ID_BITS-1:0]  bl_id_reg;
    logic                m_valid_reg, m_valid_next;
    logic [PID_BITS-1:0] pid_reg, pid_next;
    logic                emit_reg, emit_next;
    logic [ID_BITS-1:0]  anchor_reg, anchor_next;
    logic [ID_BITS-1:0]  up_reg, up_next;
    logic [ID_BITS-1:0]  left_up_reg, left_up_next;
    logic [ID_BITS-1:0]  left_reg, left_next;
    logic                ovf_reg, ovf_next;

    logic                left_up_valid;

    assign st_take = st_valid && (!m_valid_reg || m_ready);

    // Combine the line store word with the carried neighbors
    always_comb begin
        left_up_valid = ram_rdata.valid && st_item.prior_ok;
        emit_next     = st_item.sample_valid && st_item.anchor_ok
                        && left_up_valid && bl_valid_reg;

        pid_next     = st_item.sample_valid ? PID_BITS'(st_item.id) : PID_NONE;
        anchor_next  = emit_next ? st_item.below_id : '0;
        up_next      = emit_next ? st_item.id : '0;
        left_up_next = emit_next ? ram_rdata.id : '0;
        left_next    = emit_next ? bl_id_reg : '0;
        ovf_next     = st_item.overflow;

        if (st_take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state and the below-left neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            bl_valid_reg <= 1'b0;
            bl_id_reg    <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (st_take) begin
                bl_valid_reg <= left_up_valid;
                bl_id_reg    <= ram_rdata.id;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (st_take) begin
            pid_reg     <= pid_next;
            emit_reg    <= emit_next;
            anchor_reg  <= anchor_next;
            up_reg      <= up_next;
            left_up_reg <= left_up_next;
            left_reg    <= left_next;
            ovf_reg     <= ovf_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_point_id        = pid_reg;
    assign m_quad_emit       = emit_reg;
    assign m_quad_id_anchor  = anchor_reg;
    assign m_quad_id_up      = up_reg;
    assign m_quad_id_left_up = left_up_reg;
    assign m_quad_id_left    = left_reg;
    assign m_id_overflow     = ovf_reg;

endmodule

`default_nettype wire

// ===== hdl/gsqm_checker.sv =====
`default_nettype none

module gsqm_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_ready,
    input wire                           m_valid,
    input wire                           m_ready,
    input wire [gsqm_pkg::PID_BITS-1:0]  m_point_id,
    input wire                           m_quad_emit,
    input wire [gsqm_pkg::ID_BITS-1:0]   m_quad_id_anchor,
    input wire [gsqm_pkg::ID_BITS-1:0]   m_quad_id_up,
    input wire [gsqm_pkg::ID_BITS-1:0]   m_quad_id_left_up,
    input wire [gsqm_pkg::ID_BITS-1:0]   m_quad_id_left
);
    import gsqm_pkg::*;

    // No result beat right after reset, and the input side is open
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("result valid or input blocked right after reset");

    // Stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_id) && $stable(m_quad_emit))
        else $error("stalled result beat changed");

    // The current sample of an emitted quad is this beat's point
    a_up_is_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_quad_emit |-> !m_point_id[PID_BITS-1]
                                   && m_quad_id_up == m_point_id[ID_BITS-1:0])
        else $error("quad up id differs from point id");

    // Within one column the lower sample never carries a larger id
    a_id_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_quad_emit |-> m_quad_id_anchor <= m_quad_id_up)
        else $error("quad ids out of order");

    // Without a quad the quad ids are zero
    a_no_quad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_quad_emit |-> m_quad_id_anchor == '0 && m_quad_id_up == '0
                                    && m_quad_id_left_up == '0 && m_quad_id_left == '0)
        else $error("quad ids nonzero without a quad");

endmodule

bind grid_scan_quad_mesher gsqm_checker u_gsqm_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_point_id        (m_point_id),
    .m_quad_emit       (m_quad_emit),
    .m_quad_id_anchor  (m_quad_id_anchor),
    .m_quad_id_up      (m_quad_id_up),
    .m_quad_id_left_up (m_quad_id_left_up),
    .m_quad_id_left    (m_quad_id_left)
);

`default_nettype wire
